### hw/rtl/stc_pkg.sv
// Shared types and constants for the strip threshold clusterer.
// No dependencies.
package stc_pkg;

    localparam int SIGMA_W  = 16;
    localparam int SAMPLE_W = 16;
    localparam int DET_W    = 4;
    localparam int CH_W     = 9;
    localparam int AMP_W    = 24;
    localparam int NSIG_W   = 8;
    localparam int PROD_W   = SIGMA_W + NSIG_W;

    localparam logic [SIGMA_W-1:0] SIGMA_ONE   = 16'd16;
    localparam logic [AMP_W-1:0]   AMP_MAX     = 24'hFF_FFFF;
    localparam logic [CH_W-1:0]    SIZE_MAX    = 9'd511;
    localparam logic [NSIG_W-1:0]  NSIGMA_RST  = 8'd80;

    typedef enum logic {
        CMD_SAMPLE   = 1'b0,
        CMD_SIGMA_WR = 1'b1
    } command_t;

    // One cluster record, detector in the lowest bits.
    typedef struct packed {
        logic              final_item;
        logic [AMP_W-1:0]  amp;
        logic [CH_W-1:0]   size;
        logic [CH_W-1:0]   stop_ch;
        logic [CH_W-1:0]   first_ch;
        logic [DET_W-1:0]  det;
    } cluster_t;

endpackage

### hw/rtl/strip_threshold_clusterer.sv
// Strip threshold clusterer top level: sigma table memory, hit test pipeline,
// cluster tracker and result queue. Depends on stc_pkg.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata, s_tuser (command), s_tlast
//  m_      | out       | m_tvalid/m_tready  | m_tdata, m_tlast (final_of_item)
//  cfg_    | in        | cfg_wr_en          | cfg_wr_data (n_sigma)
//
// One request per cycle while s_tready is high; results enter the result queue
// from stage 2, after sigma read and threshold multiply in stage 1 and compare
// and cluster update in stage 2. After reset a clearing pass writes 1.0 to every
// sigma entry, one per cycle, with s_tready low.
// Stall: a request in the last stage waits while the 4-deep result queue
// has fewer than two free slots.
module strip_threshold_clusterer #(
    parameter int DETECTORS     = 16,
    parameter int CHANNELS      = 384,
    parameter int CHIP_CHANNELS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [3:0] detector, [12:4] channel, [28:13] sample_value, [44:29] sigma_value
    input  logic [47:0]               s_tdata,
    // [0] command
    input  logic [0:0]                s_tuser,
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [3:0] cluster_detector, [12:4] start_channel, [21:13] end_channel,
    // [30:22] cluster_size, [54:31] amplitude_sum
    output logic [55:0]               m_tdata,
    output logic                      m_tlast,
    input  logic                      cfg_wr_en,
    input  logic [stc_pkg::NSIG_W-1:0] cfg_wr_data
);
    import stc_pkg::*;

    localparam int DEPTH   = DETECTORS * CHANNELS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;
    // channel modulo CHIP_CHANNELS via reciprocal multiply
    localparam int CL      = $clog2(CHIP_CHANNELS);
    localparam int RSH     = CH_W + CL;
    localparam int RECIP   = ((1 << RSH) + CHIP_CHANNELS - 1) / CHIP_CHANNELS;

    // input unpack
    logic [DET_W-1:0]    in_det;
    logic [CH_W-1:0]     in_ch;
    logic [SAMPLE_W-1:0] in_sample;
    logic [SIGMA_W-1:0]  in_sigma;
    command_t            in_cmd;
    assign in_det    = s_tdata[3:0];
    assign in_ch     = s_tdata[12:4];
    assign in_sample = s_tdata[28:13];
    assign in_sigma  = s_tdata[44:29];
    assign in_cmd    = command_t'(s_tuser[0]);

    // control
    logic [NSIG_W-1:0] n_sigma_reg;
    logic clr_active_reg;
    logic [AW-1:0] clr_addr_reg;
    logic stall;
    logic accept;
    logic s1_valid_reg, s2_valid_reg;
    logic [QAW:0] q_count_reg;

    assign stall    = s2_valid_reg && (q_count_reg > (QAW+1)'(QDEPTH - 2));
    assign s_tready = !clr_active_reg && !stall;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_sigma_reg <= NSIGMA_RST;
        end else if (cfg_wr_en) begin
            n_sigma_reg <= cfg_wr_data;
        end
    end

    // stage 0: address, range and mask
    logic        in_range;
    logic [31:0] q_prod;
    logic [31:0] chip_idx;
    logic [CH_W-1:0] pos;
    logic        masked;
    logic [AW-1:0] in_addr;

    assign in_range = (32'(in_det) < 32'(DETECTORS)) && (32'(in_ch) < 32'(CHANNELS));
    assign q_prod   = 32'(in_ch) * 32'(RECIP);
    assign chip_idx = q_prod >> RSH;
    assign pos      = in_ch - CH_W'(chip_idx * 32'(CHIP_CHANNELS));
    assign masked   = (pos == CH_W'(0)) || (pos == CH_W'(1)) ||
                      (pos == CH_W'(CHIP_CHANNELS - 2)) ||
                      (pos == CH_W'(CHIP_CHANNELS - 1));
    assign in_addr  = AW'(32'(in_det) * 32'(CHANNELS) + 32'(in_ch));

    // sigma table
    logic [SIGMA_W-1:0] sigma_mem [DEPTH];
    logic [SIGMA_W-1:0] mem_rdata_reg;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_addr;
    logic [SIGMA_W-1:0] mem_wdata;

    assign mem_we    = clr_active_reg || (accept && in_cmd == CMD_SIGMA_WR && in_range);
    assign mem_re    = accept && in_cmd == CMD_SAMPLE && in_range;
    assign mem_addr  = clr_active_reg ? clr_addr_reg : in_addr;
    assign mem_wdata = clr_active_reg ? SIGMA_ONE : in_sigma;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sigma_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= sigma_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // stage 1: sigma read back, threshold product
    logic                s1_check_reg;
    command_t            s1_cmd_reg;
    logic [DET_W-1:0]    s1_det_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_last_reg;
    logic [SIGMA_W-1:0]  sig_eff;
    logic [PROD_W-1:0]   thr_s1;

    assign sig_eff = (mem_rdata_reg == '0) ? SIGMA_ONE : mem_rdata_reg;
    assign thr_s1  = {{NSIG_W{1'b0}}, sig_eff} * {{SIGMA_W{1'b0}}, n_sigma_reg};

    // stage 2: compare, cluster update
    logic                s2_check_reg;
    command_t            s2_cmd_reg;
    logic [DET_W-1:0]    s2_det_reg;
    logic [CH_W-1:0]     s2_ch_reg;
    logic [SAMPLE_W-1:0] s2_sample_reg;
    logic                s2_last_reg;
    logic [PROD_W-1:0]   s2_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (!stall) begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            s1_check_reg  <= in_range && !masked;
            s1_cmd_reg    <= in_cmd;
            s1_det_reg    <= in_det;
            s1_ch_reg     <= in_ch;
            s1_sample_reg <= in_sample;
            s1_last_reg   <= s_tlast;
            s2_check_reg  <= s1_check_reg;
            s2_cmd_reg    <= s1_cmd_reg;
            s2_det_reg    <= s1_det_reg;
            s2_ch_reg     <= s1_ch_reg;
            s2_sample_reg <= s1_sample_reg;
            s2_last_reg   <= s1_last_reg;
            s2_thr_reg    <= thr_s1;
        end
    end

    logic              cl_open_reg, cl_open_next;
    logic [CH_W-1:0]   open_start_reg, open_start_next;
    logic [CH_W-1:0]   prev_hit_reg, prev_hit_next;
    logic [AMP_W-1:0]  run_amp_reg, run_amp_next;
    logic [DET_W-1:0]  open_det_reg, open_det_next;

    logic              s2_go, is_sample, hit, close_a, close_b, open_mid;
    logic [PROD_W-1:0] val16;
    logic [AMP_W:0]    amp_sum;
    logic [AMP_W-1:0]  amp_in;
    cluster_t          rec_a, rec_b;

    function automatic logic [CH_W-1:0] clus_size(input logic [CH_W-1:0] first,
                                                   input logic [CH_W-1:0] last);
        logic [CH_W:0] span;
        begin
            span = {1'b0, last} - {1'b0, first} + (CH_W+1)'(1);
            if (last < first) begin
                clus_size = CH_W'(1);
            end else if (span > {1'b0, SIZE_MAX}) begin
                clus_size = SIZE_MAX;
            end else begin
                clus_size = span[CH_W-1:0];
            end
        end
    endfunction

    assign s2_go     = s2_valid_reg && !stall;
    assign is_sample = s2_cmd_reg == CMD_SAMPLE;
    assign val16     = {{(PROD_W-SAMPLE_W-3){1'b0}}, s2_sample_reg[SAMPLE_W-2:0], 4'b0000};
    assign hit       = is_sample && s2_check_reg && !s2_sample_reg[SAMPLE_W-1] &&
                       (val16 > s2_thr_reg);
    assign amp_in    = {{(AMP_W-SAMPLE_W){1'b0}}, s2_sample_reg};
    assign amp_sum   = {1'b0, run_amp_reg} + {1'b0, amp_in};

    assign close_a  = is_sample && cl_open_reg &&
                      (!hit || s2_det_reg != open_det_reg ||
                       {1'b0, s2_ch_reg} != {1'b0, prev_hit_reg} + (CH_W+1)'(1));
    assign open_mid = cl_open_reg && !close_a;

    always_comb begin
        open_start_next = open_start_reg;
        prev_hit_next   = prev_hit_reg;
        run_amp_next    = run_amp_reg;
        open_det_next   = open_det_reg;
        cl_open_next    = open_mid;
        if (hit) begin
            cl_open_next  = 1'b1;
            prev_hit_next = s2_ch_reg;
            if (open_mid) begin
                run_amp_next = amp_sum[AMP_W] ? AMP_MAX : amp_sum[AMP_W-1:0];
            end else begin
                open_start_next = s2_ch_reg;
                open_det_next   = s2_det_reg;
                run_amp_next    = amp_in;
            end
        end
        close_b = is_sample && s2_last_reg && cl_open_next;
        if (close_b) begin
            cl_open_next = 1'b0;
        end
    end

    always_comb begin
        rec_a.final_item = !close_b;
        rec_a.amp        = run_amp_reg;
        rec_a.size       = clus_size(open_start_reg, prev_hit_reg);
        rec_a.stop_ch    = prev_hit_reg;
        rec_a.first_ch   = open_start_reg;
        rec_a.det        = open_det_reg;
        rec_b.final_item = 1'b1;
        rec_b.amp        = run_amp_next;
        rec_b.size       = clus_size(open_start_next, prev_hit_next);
        rec_b.stop_ch    = prev_hit_next;
        rec_b.first_ch   = open_start_next;
        rec_b.det        = open_det_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cl_open_reg    <= 1'b0;
            open_start_reg <= '0;
            prev_hit_reg   <= '0;
            run_amp_reg    <= '0;
            open_det_reg   <= '0;
        end else if (s2_go) begin
            cl_open_reg    <= cl_open_next;
            open_start_reg <= open_start_next;
            prev_hit_reg   <= prev_hit_next;
            run_amp_reg    <= run_amp_next;
            open_det_reg   <= open_det_next;
        end
    end

    // result queue
    cluster_t       q_mem [QDEPTH];
    logic [QAW-1:0] q_wr_reg, q_rd_reg;
    logic           push_a, push_b, pop;
    cluster_t       q_head;

    assign push_a = s2_go && close_a;
    assign push_b = s2_go && close_b;
    assign pop    = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (push_a) begin
            q_mem[q_wr_reg] <= rec_a;
        end
        if (push_b) begin
            q_mem[push_a ? q_wr_reg + QAW'(1) : q_wr_reg] <= rec_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg    <= '0;
            q_rd_reg    <= '0;
            q_count_reg <= '0;
        end else begin
            q_wr_reg    <= q_wr_reg + QAW'(push_a) + QAW'(push_b);
            q_rd_reg    <= q_rd_reg + QAW'(pop);
            q_count_reg <= q_count_reg + (QAW+1)'(push_a) + (QAW+1)'(push_b)
                           - (QAW+1)'(pop);
        end
    end

    assign q_head   = q_mem[q_rd_reg];
    assign m_tvalid = q_count_reg != '0;
    assign m_tdata  = {1'b0, q_head.amp, q_head.size, q_head.stop_ch,
                       q_head.first_ch, q_head.det};
    assign m_tlast  = q_head.final_item;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

    a_open_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cl_open_reg |-> (prev_hit_reg >= open_start_reg))
        else $error("open cluster ends before its start");

    a_two_needs_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_a && push_b) |-> (s2_last_reg && hit))
        else $error("two results without a closing hit on last channel");

    a_stall_holds_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (stall && s1_valid_reg) |=> $stable(mem_rdata_reg))
        else $error("sigma read data lost during stall");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !mem_re)
        else $error("sample read during clearing pass");

endmodule

### tb/sv/tb_strip_threshold_clusterer.sv
`timescale 1ns / 1ps
// Self-checking bench for strip_threshold_clusterer: directed table, then random
// detector scans under several n_sigma settings, checked against a local cluster model.
// Depends on stc_pkg and the strip_threshold_clusterer RTL.
module tb_strip_threshold_clusterer;
    import stc_pkg::*;

    localparam int DETECTORS     = 16;
    localparam int CHANNELS      = 384;
    localparam int CHIP_CHANNELS = 64;
    localparam int TABLE_DEPTH   = DETECTORS * CHANNELS;
    localparam int STALL_LIMIT   = 30000;
    localparam int PHASE_ITEMS   = 330;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        command_t            cmd;
        logic [DET_W-1:0]    det;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] sample;
        logic [SIGMA_W-1:0]  sigma;
        logic                last;
    } strip_req_t;

    typedef struct {
        strip_req_t req;
        int         n_typed;
        cluster_t   e0;
        cluster_t   e1;
    } dir_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [47:0]        s_tdata;
    logic [0:0]         s_tuser;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [55:0]        m_tdata;
    logic               m_tlast;
    logic               cfg_wr_en;
    logic [NSIG_W-1:0]  cfg_wr_data;

    // local copy of block state
    logic [SIGMA_W-1:0] sigma_mem [0:TABLE_DEPTH-1];
    logic [NSIG_W-1:0]  nsig_q;
    bit                 open_q;
    int                 open_start;
    int                 prev_hit;
    int                 run_amp;
    int                 open_det;

    cluster_t           pending_clusters [$];
    dir_row_t           dir_rows [$];
    int                 errors;
    int                 stall_cycles;
    bit                 calm;

    strip_threshold_clusterer #(
        .DETECTORS     (DETECTORS),
        .CHANNELS      (CHANNELS),
        .CHIP_CHANNELS (CHIP_CHANNELS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit chip_edge(int ch);
        int pos;
        pos = ch % CHIP_CHANNELS;
        return pos == 0 || pos == 1 || pos == CHIP_CHANNELS - 2 || pos == CHIP_CHANNELS - 1;
    endfunction

    function automatic cluster_t close_cluster();
        cluster_t c;
        int sz;
        sz = prev_hit - open_start + 1;
        if (prev_hit < open_start) sz = 1;
        if (sz > 511) sz = 511;
        c.det        = open_det[DET_W-1:0];
        c.first_ch   = open_start[CH_W-1:0];
        c.stop_ch    = prev_hit[CH_W-1:0];
        c.size       = sz[CH_W-1:0];
        c.amp        = run_amp[AMP_W-1:0];
        c.final_item = 1'b0;
        open_q = 1'b0;
        return c;
    endfunction

    // Advances the local state by one request, returns the number of clusters it closes.
    function automatic int cluster_step(input strip_req_t r, output cluster_t c0,
                                        output cluster_t c1);
        int n;
        bit hit;
        bit in_rng;
        int v;
        int sig;
        int idx;
        int amp_max;
        cluster_t cur;
        n = 0;
        hit = 1'b0;
        c0 = '0;
        c1 = '0;
        amp_max = int'(AMP_MAX);
        in_rng = int'(r.det) < DETECTORS && int'(r.ch) < CHANNELS;
        idx = int'(r.det) * CHANNELS + int'(r.ch);
        if (r.cmd == CMD_SIGMA_WR) begin
            if (in_rng) sigma_mem[idx] = r.sigma;
            return 0;
        end
        v = int'($signed(r.sample));
        if (in_rng && !chip_edge(int'(r.ch))) begin
            sig = int'(sigma_mem[idx]);
            if (sig == 0) sig = int'(SIGMA_ONE);
            hit = longint'(v) * 16 > longint'(nsig_q) * longint'(sig);
        end
        if (open_q && (!hit || int'(r.det) != open_det || int'(r.ch) != prev_hit + 1)) begin
            c0 = close_cluster();
            n = 1;
        end
        if (hit) begin
            if (open_q) begin
                run_amp = (run_amp > amp_max - v) ? amp_max : run_amp + v;
            end else begin
                open_q     = 1'b1;
                open_start = int'(r.ch);
                open_det   = int'(r.det);
                run_amp    = (v > amp_max) ? amp_max : v;
            end
            prev_hit = int'(r.ch);
        end
        if (r.last && open_q) begin
            cur = close_cluster();
            if (n == 0) c0 = cur;
            else c1 = cur;
            n++;
        end
        if (n == 1) c0.final_item = 1'b1;
        if (n == 2) c1.final_item = 1'b1;
        return n;
    endfunction

    function automatic strip_req_t mk_req(command_t cmd, int det, int ch, int sample,
                                          int sigma, bit last);
        strip_req_t r;
        r.cmd    = cmd;
        r.det    = det[DET_W-1:0];
        r.ch     = ch[CH_W-1:0];
        r.sample = sample[SAMPLE_W-1:0];
        r.sigma  = sigma[SIGMA_W-1:0];
        r.last   = last;
        return r;
    endfunction

    function automatic cluster_t clus(int det, int s, int e, int sz, int amp, bit fin);
        cluster_t c;
        c.det        = det[DET_W-1:0];
        c.first_ch   = s[CH_W-1:0];
        c.stop_ch    = e[CH_W-1:0];
        c.size       = sz[CH_W-1:0];
        c.amp        = amp[AMP_W-1:0];
        c.final_item = fin;
        return c;
    endfunction

    function automatic void add_row(strip_req_t r, int n, cluster_t e0, cluster_t e1);
        dir_row_t row;
        row.req     = r;
        row.n_typed = n;
        row.e0      = e0;
        row.e1      = e1;
        dir_rows = {dir_rows, row};
    endfunction

    // Sample value spread around the current hit threshold of a channel.
    function automatic logic [SAMPLE_W-1:0] pick_value(int det, int ch);
        longint thr;
        int sig;
        int r;
        sig = (ch < CHANNELS) ? int'(sigma_mem[det * CHANNELS + ch]) : int'(SIGMA_ONE);
        if (sig == 0) sig = int'(SIGMA_ONE);
        thr = (longint'(nsig_q) * sig) / 16;
        r = $urandom_range(0, 99);
        if (r < 55) thr = thr + 1 + $urandom_range(0, 300);
        else if (r < 75) thr = thr - 1 + $urandom_range(0, 2);
        else if (r < 90) thr = $urandom_range(0, 100);
        else return SAMPLE_W'($urandom);
        if (thr > 32767) thr = 32767;
        if (thr < -32768) thr = -32768;
        return thr[SAMPLE_W-1:0];
    endfunction

    // Called at a falling edge, returns at the falling edge after acceptance.
    task automatic push_req(strip_req_t r, int n_typed, cluster_t e0, cluster_t e1);
        cluster_t c0;
        cluster_t c1;
        int n;
        if (!calm) begin
            while ($urandom_range(0, 99) < 13) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, r.sigma, r.sample, r.ch, r.det};
        s_tuser  <= r.cmd;
        s_tlast  <= r.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n = cluster_step(r, c0, c1);
        if (n_typed >= 0) begin
            n  = n_typed;
            c0 = e0;
            c1 = e1;
        end
        if (n > 0) pending_clusters = {pending_clusters, c0};
        if (n > 1) pending_clusters = {pending_clusters, c1};
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_clusters.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_threshold(logic [NSIG_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        nsig_q = value;
    endtask

    task automatic run_phase();
        strip_req_t r;
        int count;
        int sel;
        int det;
        int start;
        int len;
        int ch;
        count = 0;
        while (count < PHASE_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                r = mk_req(command_t'($urandom_range(0, 1)), $urandom_range(0, 15),
                           $urandom_range(0, 511), $urandom, $urandom, $urandom_range(0, 1));
                push_req(r, -1, '0, '0);
                if (!(r.cmd == CMD_SIGMA_WR && int'(r.ch) >= CHANNELS)) count++;
            end else if (sel < 20) begin
                r = mk_req(CMD_SIGMA_WR, $urandom_range(0, 15), $urandom_range(0, CHANNELS - 1),
                           $urandom, ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40),
                           $urandom_range(0, 1));
                push_req(r, -1, '0, '0);
                count++;
            end else begin
                det   = $urandom_range(0, 15);
                start = $urandom_range(0, CHANNELS - 1);
                len   = $urandom_range(1, 12);
                for (int i = 0; i < len && start + i < CHANNELS; i++) begin
                    ch = start + i;
                    r = mk_req(CMD_SAMPLE, det, ch, int'(pick_value(det, ch)), $urandom,
                               (i == len - 1) && ($urandom_range(0, 1) == 1));
                    push_req(r, -1, '0, '0);
                    count++;
                end
            end
        end
    endtask

    task automatic check_field(string name, longint want, longint got);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %0d, got %0d", name, want, got);
    endtask

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 13);
    end

    always @(posedge aclk) begin
        cluster_t got;
        cluster_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tlast, m_tdata[54:0]};
            if (pending_clusters.size() == 0) begin
                check_field("unexpected cluster, detector", -1, got.det);
            end else begin
                want = pending_clusters.pop_front();
                if (got.det != want.det) check_field("detector", want.det, got.det);
                if (got.first_ch != want.first_ch)
                    check_field("start_channel", want.first_ch, got.first_ch);
                if (got.stop_ch != want.stop_ch)
                    check_field("end_channel", want.stop_ch, got.stop_ch);
                if (got.size != want.size) check_field("cluster_size", want.size, got.size);
                if (got.amp != want.amp) check_field("amplitude_sum", want.amp, got.amp);
                if (got.final_item != want.final_item)
                    check_field("final_of_item", want.final_item, got.final_item);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [NSIG_W-1:0] settings [6];
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        errors       = 0;
        stall_cycles = 0;
        calm         = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) sigma_mem[i] = SIGMA_ONE;
        nsig_q     = NSIGMA_RST;
        open_q     = 1'b0;
        open_start = 0;
        prev_hit   = 0;
        run_amp    = 0;
        open_det   = 0;

        // reset threshold 5.0 with sigma 1.0: a hit needs a value above 80
        add_row(mk_req(CMD_SAMPLE, 0, 2, 81, 0, 0), 0, '0, '0);
        add_row(mk_req(CMD_SAMPLE, 0, 3, 80, 0, 0), 1, clus(0, 2, 2, 1, 81, 1), '0);
        add_row(mk_req(CMD_SAMPLE, 0, 0, 32767, 0, 1), 0, '0, '0);
        add_row(mk_req(CMD_SAMPLE, 15, 381, 32767, 65535, 1), 1,
                clus(15, 381, 381, 1, 32767, 1), '0);
        add_row(mk_req(CMD_SAMPLE, 3, 500, 32767, 0, 1), 0, '0, '0);
        add_row(mk_req(CMD_SAMPLE, 1, 10, -32768, 0, 0), 0, '0, '0);
        // zero sigma reads as 1.0
        add_row(mk_req(CMD_SIGMA_WR, 2, 20, 0, 0, 0), 0, '0, '0);
        add_row(mk_req(CMD_SAMPLE, 2, 20, 81, 0, 0), 0, '0, '0);
        add_row(mk_req(CMD_SIGMA_WR, 2, 21, 0, 65535, 1), 0, '0, '0);
        add_row(mk_req(CMD_SAMPLE, 2, 21, 32767, 0, 0), 1, clus(2, 20, 20, 1, 81, 1), '0);
        // out of range write must not alias onto detector 6 channel 16
        add_row(mk_req(CMD_SIGMA_WR, 5, 400, 0, 65535, 0), 0, '0, '0);
        add_row(mk_req(CMD_SAMPLE, 6, 16, 100, 0, 1), 1, clus(6, 16, 16, 1, 100, 1), '0);
        // detector change closes and reopens
        add_row(mk_req(CMD_SAMPLE, 4, 30, 100, 0, 0), 0, '0, '0);
        add_row(mk_req(CMD_SAMPLE, 5, 31, 200, 0, 0), 1, clus(4, 30, 30, 1, 100, 1), '0);
        add_row(mk_req(CMD_SAMPLE, 5, 32, 300, 0, 1), 1, clus(5, 31, 32, 2, 500, 1), '0);
        // gap hit with last: two clusters
        add_row(mk_req(CMD_SAMPLE, 6, 40, 90, 0, 0), 0, '0, '0);
        add_row(mk_req(CMD_SAMPLE, 6, 45, 95, 0, 1), 2, clus(6, 40, 40, 1, 90, 0),
                clus(6, 45, 45, 1, 95, 1));
        add_row(mk_req(CMD_SAMPLE, 7, 50, 90, 0, 0), 0, '0, '0);
        add_row(mk_req(CMD_SAMPLE, 7, 384, 32767, 0, 0), 1, clus(7, 50, 50, 1, 90, 1), '0);
        add_row(mk_req(CMD_SAMPLE, 8, 60, 90, 0, 0), 0, '0, '0);
        add_row(mk_req(CMD_SAMPLE, 8, 62, 32767, 0, 0), 1, clus(8, 60, 60, 1, 90, 1), '0);
        // table write inside an open cluster leaves it alone
        add_row(mk_req(CMD_SAMPLE, 9, 100, 90, 0, 0), 0, '0, '0);
        add_row(mk_req(CMD_SIGMA_WR, 9, 101, 0, 0, 1), 0, '0, '0);
        add_row(mk_req(CMD_SAMPLE, 9, 101, 95, 0, 1), 1, clus(9, 100, 101, 2, 185, 1), '0);

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) push_req(dir_rows[i].req, dir_rows[i].n_typed,
                                       dir_rows[i].e0, dir_rows[i].e1);

        settings[0] = 8'd0;
        settings[1] = 8'd255;
        settings[2] = 8'd16;
        settings[3] = 8'd40;
        settings[4] = 8'd128;
        settings[5] = NSIG_W'($urandom_range(1, 254));
        for (int p = 0; p < 6; p++) begin
            set_threshold(settings[p]);
            calm = (p == 2);
            run_phase();
        end
        calm = 1'b0;

        settle();
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_clusters.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/stc_pkg.sv
hw/rtl/strip_threshold_clusterer.sv
tb/sv/tb_strip_threshold_clusterer.sv
